/* hdl/kpcl_pkg.sv */
// Package: shared types, constants and codes for the kerning pair class lookup.
package kpcl_pkg;

    localparam int MAP_DEPTH   = 512;
    localparam int ROW_DEPTH   = 256;
    localparam int VALUE_DEPTH = 8192;

    localparam int MAP_AW   = $clog2(MAP_DEPTH);
    localparam int ROW_AW   = $clog2(ROW_DEPTH);
    localparam int VALUE_AW = $clog2(VALUE_DEPTH);

    localparam logic [20:0] CODEPOINT_LIMIT = 21'h00FFFF;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_LEFT   = 3'd1,
        CMD_RIGHT  = 3'd2,
        CMD_ROW    = 3'd3,
        CMD_SPARSE = 3'd4,
        CMD_DENSE  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        FORM_NONE   = 2'd0,
        FORM_DENSE  = 2'd1,
        FORM_SPARSE = 2'd2
    } form_t;

    typedef enum logic [1:0] {
        REG_FORM  = 2'd0,
        REG_LEFT  = 2'd1,
        REG_RIGHT = 2'd2,
        REG_TOTAL = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LPROBE,
        ST_LWAIT,
        ST_RPROBE,
        ST_RWAIT,
        ST_DISPATCH,
        ST_ROW0,
        ST_ROW1,
        ST_ROWW,
        ST_SCAN,
        ST_SCANW,
        ST_DENSE_MUL,
        ST_DENSE_RD,
        ST_DENSE_W,
        ST_OUT
    } state_t;

    // search unit control
    typedef struct packed {
        logic        start;
        logic [10:0] count;
        logic [20:0] cp;
    } srch_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] cls;
    } srch_rsp_t;

endpackage

/* hdl/kpcl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module kpcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/kpcl_search.sv */
// Lower-bound binary search over one codepoint-to-class map memory.
module kpcl_search (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kpcl_pkg::srch_req_t   req,
    input  logic                  wr_en,
    input  logic [kpcl_pkg::MAP_AW-1:0] wr_addr,
    input  logic [23:0]           wr_data,
    output kpcl_pkg::srch_rsp_t   rsp
);
    import kpcl_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PROBE, S_WAIT, S_FINAL} sst_t;

    sst_t            st_reg, st_next;
    logic [MAP_AW:0] first_reg, first_next;
    logic [MAP_AW:0] len_reg, len_next;
    logic [MAP_AW:0] cnt_reg, cnt_next;
    logic [15:0]     cp_reg, cp_next;
    logic            big_reg, big_next;
    logic [7:0]      cls_reg, cls_next;
    logic            done_reg, done_next;
    logic [MAP_AW:0] half, mid;
    logic [MAP_AW-1:0] raddr;
    logic [23:0]     rdata;

    kpcl_ram #(.WIDTH(24), .DEPTH(MAP_DEPTH)) u_map (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
        .raddr(raddr), .rdata(rdata)
    );

    assign half = len_reg >> 1;
    assign mid  = first_reg + half;

    always_comb begin
        raddr = mid[MAP_AW-1:0];
        if (st_reg == S_FINAL || len_reg == '0) begin
            raddr = first_reg[MAP_AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        first_reg <= first_next;
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        cp_reg    <= cp_next;
        big_reg   <= big_next;
        cls_reg   <= cls_next;
    end

    always_comb begin
        st_next    = st_reg;
        first_next = first_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        cp_next    = cp_reg;
        big_next   = big_reg;
        cls_next   = cls_reg;
        done_next  = 1'b0;
        case (st_reg)
            S_IDLE: begin
                if (req.start) begin
                    first_next = '0;
                    cnt_next   = (req.count > 11'(MAP_DEPTH)) ? (MAP_AW+1)'(MAP_DEPTH)
                                                              : req.count[MAP_AW:0];
                    len_next   = cnt_next;
                    cp_next    = req.cp[15:0];
                    big_next   = req.cp > CODEPOINT_LIMIT;
                    st_next    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (big_reg || cnt_reg == '0) begin
                    cls_next  = '0;
                    done_next = 1'b1;
                    st_next   = S_IDLE;
                end else if (len_reg == '0) begin
                    st_next = S_FINAL;
                end else begin
                    st_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (rdata[23:8] < cp_reg) begin
                    first_next = mid + 1'b1;
                    len_next   = len_reg - half - 1'b1;
                end else begin
                    len_next = half;
                end
                st_next = S_PROBE;
            end
            S_FINAL: begin
                cls_next  = (first_reg < cnt_reg && rdata[23:8] == cp_reg) ? rdata[7:0] : '0;
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.cls  = cls_reg;
endmodule

/* hdl/kern_pair_class_lookup_core.sv */
// Top level: kerning pair class lookup with map searches and kern matrix access.
//
// Usage: input words arrive on the s_ channel; commands 1..5 load the maps,
// row starts, sparse columns and kern values (no result). A lookup
// (command 0) searches the left map, then the right map, by lower-bound
// binary search, then reads the kern value: dense form multiplies, then
// reads; sparse form reads two row starts, then scans the row entry by
// entry. One result word per lookup on m_.
// One item is in flight at a time; s_tready is low while a lookup runs or
// while a result waits. The output register holds the word while
// m_tready is low. Reset (synchronous, aresetn low) clears control state
// and configuration; memory contents are undefined until written.
// Config writes land on cfg_we with no handshake and must occur when idle.
module kern_pair_class_lookup_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], index[15:3], key[31:16], class_or_offset[45:32],
    // kern_entry[53:46], left_codepoint[74:54], right_codepoint[95:75]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kern_value[7:0], left_class[15:8], right_class[23:16]
    output logic [23:0] m_tdata
);
    import kpcl_pkg::*;

    logic [1:0] form_reg;
    logic [9:0] lent_reg, rent_reg;
    logic [7:0] rtot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            form_reg <= '0; lent_reg <= '0; rent_reg <= '0; rtot_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_FORM:  form_reg <= cfg_wdata[1:0];
                REG_LEFT:  lent_reg <= cfg_wdata;
                REG_RIGHT: rent_reg <= cfg_wdata;
                REG_TOTAL: rtot_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic [2:0]  f_cmd;
    logic [12:0] f_idx;
    logic [15:0] f_key;
    logic [13:0] f_cls;
    logic [7:0]  f_kern;
    logic [20:0] f_lcp, f_rcp;
    assign f_cmd  = s_tdata[2:0];
    assign f_idx  = s_tdata[15:3];
    assign f_key  = s_tdata[31:16];
    assign f_cls  = s_tdata[45:32];
    assign f_kern = s_tdata[53:46];
    assign f_lcp  = s_tdata[74:54];
    assign f_rcp  = s_tdata[95:75];

    state_t st_reg, st_next;
    logic   acc;
    assign acc = s_tvalid && s_tready;

    // writes, decoded directly from the accepted word
    logic wr_l, wr_r, wr_row, wr_col, wr_kv;
    assign wr_l   = acc && f_cmd == CMD_LEFT && f_idx < 13'(MAP_DEPTH);
    assign wr_r   = acc && f_cmd == CMD_RIGHT && f_idx < 13'(MAP_DEPTH);
    assign wr_row = acc && f_cmd == CMD_ROW && f_idx < 13'(ROW_DEPTH);
    assign wr_col = acc && f_cmd == CMD_SPARSE && 14'(f_idx) < 14'(VALUE_DEPTH);
    assign wr_kv  = acc && (f_cmd == CMD_SPARSE || f_cmd == CMD_DENSE)
                    && 14'(f_idx) < 14'(VALUE_DEPTH);

    logic [20:0] rcp_reg;
    logic [7:0]  lc_reg, rc_reg, kv_reg;
    logic        ov_reg;
    logic [13:0] ptr_reg, end_reg;
    logic [15:0] prod_reg;
    logic [20:0] rcp_next;
    logic [7:0]  lc_next, rc_next, kv_next;
    logic [13:0] ptr_next, end_next;

    srch_req_t lreq, rreq;
    srch_rsp_t lrsp, rrsp;

    always_comb begin
        lreq.start = acc && f_cmd == CMD_LOOKUP;
        lreq.count = {1'b0, lent_reg};
        lreq.cp    = f_lcp;
        rreq.start = st_reg == ST_RPROBE;
        rreq.count = {1'b0, rent_reg};
        rreq.cp    = rcp_reg;
    end

    kpcl_search u_lsrch (
        .aclk(aclk), .aresetn(aresetn), .req(lreq),
        .wr_en(wr_l), .wr_addr(f_idx[MAP_AW-1:0]), .wr_data({f_key, f_cls[7:0]}),
        .rsp(lrsp)
    );
    kpcl_search u_rsrch (
        .aclk(aclk), .aresetn(aresetn), .req(rreq),
        .wr_en(wr_r), .wr_addr(f_idx[MAP_AW-1:0]), .wr_data({f_key, f_cls[7:0]}),
        .rsp(rrsp)
    );

    logic [ROW_AW-1:0]   row_ra;
    logic [13:0]         row_rd;
    logic [VALUE_AW-1:0] val_ra;
    logic [7:0]          col_rd, kv_rd;

    kpcl_ram #(.WIDTH(14), .DEPTH(ROW_DEPTH)) u_rows (
        .aclk(aclk), .we(wr_row), .waddr(f_idx[ROW_AW-1:0]), .wdata(f_cls),
        .raddr(row_ra), .rdata(row_rd)
    );
    kpcl_ram #(.WIDTH(8), .DEPTH(VALUE_DEPTH)) u_cols (
        .aclk(aclk), .we(wr_col), .waddr(f_idx[VALUE_AW-1:0]), .wdata(f_key[7:0]),
        .raddr(val_ra), .rdata(col_rd)
    );
    kpcl_ram #(.WIDTH(8), .DEPTH(VALUE_DEPTH)) u_kv (
        .aclk(aclk), .we(wr_kv), .waddr(f_idx[VALUE_AW-1:0]), .wdata(f_kern),
        .raddr(val_ra), .rdata(kv_rd)
    );

    logic [8:0]  lcm1;
    logic [16:0] didx;
    logic [7:0]  tgt;
    assign lcm1 = {1'b0, lc_reg} - 9'd1;
    assign tgt  = rc_reg - 8'd1;
    assign didx = {1'b0, prod_reg} + {9'b0, tgt};

    always_comb begin
        row_ra = lcm1[ROW_AW-1:0];
        if (st_reg == ST_ROW1) row_ra = lc_reg[ROW_AW-1:0];
        val_ra = ptr_reg[VALUE_AW-1:0];
        if (st_reg == ST_DENSE_RD) val_ra = didx[VALUE_AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
        rcp_reg  <= rcp_next;
        lc_reg   <= lc_next;
        rc_reg   <= rc_next;
        kv_reg   <= kv_next;
        ptr_reg  <= ptr_next;
        end_reg  <= end_next;
        prod_reg <= 16'(lcm1[7:0] * rtot_reg);
        ov_reg   <= didx >= 17'(VALUE_DEPTH);
    end

    always_comb begin
        st_next  = st_reg;
        rcp_next = rcp_reg;
        lc_next  = lc_reg;
        rc_next  = rc_reg;
        kv_next  = kv_reg;
        ptr_next = ptr_reg;
        end_next = end_reg;
        case (st_reg)
            ST_IDLE: begin
                if (acc && f_cmd == CMD_LOOKUP) begin
                    rcp_next = f_rcp;
                    kv_next  = '0;
                    st_next  = ST_LWAIT;
                end
            end
            ST_LWAIT: begin
                if (lrsp.done) begin
                    lc_next = lrsp.cls;
                    st_next = ST_RPROBE;
                end
            end
            ST_RPROBE: st_next = ST_RWAIT;
            ST_RWAIT: begin
                if (rrsp.done) begin
                    rc_next = rrsp.cls;
                    st_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (lc_reg == '0 || rc_reg == '0) st_next = ST_OUT;
                else if (form_reg == FORM_SPARSE)
                    st_next = (9'(lc_reg) >= 9'(ROW_DEPTH)) ? ST_OUT : ST_ROW0;
                else if (form_reg == FORM_DENSE) st_next = ST_DENSE_MUL;
                else st_next = ST_OUT;
            end
            ST_ROW0: st_next = ST_ROW1;
            ST_ROW1: begin
                ptr_next = row_rd;
                st_next  = ST_ROWW;
            end
            ST_ROWW: begin
                end_next = row_rd;
                st_next  = ST_SCAN;
            end
            ST_SCAN: begin
                if (ptr_reg >= end_reg || ptr_reg >= 14'(VALUE_DEPTH)) st_next = ST_OUT;
                else st_next = ST_SCANW;
            end
            ST_SCANW: begin
                if (col_rd == tgt) begin
                    kv_next = kv_rd;
                    st_next = ST_OUT;
                end else if (col_rd > tgt) begin
                    st_next = ST_OUT;
                end else begin
                    ptr_next = ptr_reg + 14'd1;
                    st_next  = ST_SCAN;
                end
            end
            ST_DENSE_MUL: st_next = ST_DENSE_RD;
            ST_DENSE_RD:  st_next = ST_DENSE_W;
            ST_DENSE_W: begin
                kv_next = ov_reg ? 8'd0 : kv_rd;
                st_next = ST_OUT;
            end
            ST_OUT: if (m_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    assign s_tready = st_reg == ST_IDLE;
    assign m_tvalid = st_reg == ST_OUT;
    assign m_tdata  = {rc_reg, lc_reg, kv_reg};
endmodule
